// ----- hdl/spv_pkg.sv -----
// ----------------------------------------------------------------------------
// spv_pkg: shared definitions for the SHA-256 proof-of-work verifier
// Round constants, initial hash values, SHA-256 helper functions, the
// command group between controller and datapath, and register decoding.
// ----------------------------------------------------------------------------
package spv_pkg;

  // Field widths of the streaming payloads.
  localparam int unsigned IN_DATA_W  = 288;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned ROUNDS     = 64;
  localparam int unsigned RND_W      = $clog2(ROUNDS);

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  // Register index is paddr[2]; the threshold is register zero.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic [31:0] THRESHOLD_RESET = 32'h0000_5FFF;

  // Fixed words of the padded block for a 36-byte message.
  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [31:0] LEN_WORD = 32'h0000_0120;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;     // take a new item and set up the block
    logic             round;    // run one compression round
    logic             capture;  // finish the digest word into the output register
    logic [RND_W-1:0] rnd;      // current round number
  } spv_cmd_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- hdl/spv_ctrl.sv -----
// ----------------------------------------------------------------------------
// spv_ctrl: sequencing controller
// Accepts one item at a time, counts the 64 rounds and hands the finished
// result to the output register once that register is free.
// ----------------------------------------------------------------------------
module spv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output spv_pkg::spv_cmd_t cmd
);
  import spv_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [RND_W-1:0] cnt_r, cnt_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    cmd            = '0;
    cmd.rnd        = cnt_r;
    in_tready      = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == RND_W'(ROUNDS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.capture    = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, round counter and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

// ----- hdl/spv_datapath.sv -----
// ----------------------------------------------------------------------------
// spv_datapath: SHA-256 round datapath
// Holds the 16-word message schedule window, the eight working words and
// the output register; runs one compression round per command.
// ----------------------------------------------------------------------------
module spv_datapath (
  input  logic                               clk,
  input  spv_pkg::spv_cmd_t                  cmd,
  input  logic [spv_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [31:0]                        threshold,
  output logic                               accepted,
  output logic [31:0]                        digest_head
);
  import spv_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] st_r [8];
  logic        accepted_r;
  logic [31:0] head_r;

  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] head_raw;
  logic [31:0] head_le;

  // Round function and schedule extension.
  always_comb begin
    ch    = (st_r[4] & st_r[5]) ^ (~st_r[4] & st_r[6]);
    maj   = (st_r[0] & st_r[1]) ^ (st_r[0] & st_r[2]) ^ (st_r[1] & st_r[2]);
    t1    = st_r[7] + big_sigma1(st_r[4]) + ch + ROUND_K[cmd.rnd] + w_r[0];
    t2    = big_sigma0(st_r[0]) + maj;
    w_new = w_r[0] + small_sigma0(w_r[1]) + w_r[9] + small_sigma1(w_r[14]);
  end

  // First digest word, read back little-endian.
  assign head_raw = INIT_H[0] + st_r[0];
  assign head_le  = swap32(head_raw);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // Challenge words give message words 0..7, the nonce word 8.
      for (int i = 0; i < 8; i++) begin
        w_r[i] <= swap32(in_tdata[32*i +: 32]);
      end
      w_r[8]  <= swap32(in_tdata[287:256]);
      w_r[9]  <= PAD_WORD;
      for (int i = 10; i < 15; i++) begin
        w_r[i] <= '0;
      end
      w_r[15] <= LEN_WORD;
      for (int i = 0; i < 8; i++) begin
        st_r[i] <= INIT_H[i];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
      st_r[7] <= st_r[6];
      st_r[6] <= st_r[5];
      st_r[5] <= st_r[4];
      st_r[4] <= st_r[3] + t1;
      st_r[3] <= st_r[2];
      st_r[2] <= st_r[1];
      st_r[1] <= st_r[0];
      st_r[0] <= t1 + t2;
    end

    // Output register.
    if (cmd.capture) begin
      head_r     <= head_le;
      accepted_r <= (head_le <= threshold);
    end
  end

  assign accepted    = accepted_r;
  assign digest_head = head_r;

endmodule

// ----- hdl/sha256_pow_verifier_unit.sv -----
// ----------------------------------------------------------------------------
// sha256_pow_verifier_unit: SHA-256 proof-of-work check
// Hashes a 32-byte challenge with a 32-bit little-endian answer and checks
// the first digest word against a programmable difficulty threshold.
// ----------------------------------------------------------------------------
// Each item passes from the input transfer to the result being offered
// through a load step, 64 compression rounds on the single round unit
// (one round per cycle), and a final step that adds the initial hash word,
// swaps its bytes and compares with the threshold. The next item can be
// taken in the same cycle that the result is offered, and not before; a
// stalled output holds the finished item until its register is free. The
// threshold register resets to 0x00005FFF; only paddr[2] is decoded, so
// byte addresses 0 to 3 reach it and writes to other addresses are ignored.
module sha256_pow_verifier_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: challenge_w0[63:0], challenge_w1[127:64],
  // challenge_w2[191:128], challenge_w3[255:192], answer_nonce[287:256].
  input  logic [spv_pkg::IN_DATA_W-1:0]  in_tdata,
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: accepted[0], digest_head[32:1], zero fill [39:33].
  output logic [spv_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration port.
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [spv_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import spv_pkg::*;

  spv_cmd_t    cmd;
  logic [31:0] threshold_r;
  logic        accepted;
  logic [31:0] digest_head;
  logic        reg_hit;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == REG_THRESHOLD);

  // Threshold register, written on the access cycle of a write transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      threshold_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = reg_hit ? threshold_r : '0;

  spv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spv_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .in_tdata    (in_tdata),
    .threshold   (threshold_r),
    .accepted    (accepted),
    .digest_head (digest_head)
  );

  assign out_tdata = {7'b0, digest_head, accepted};

endmodule

// ----- tb/sv/sha256_pow_verifier_unit_test.sv -----
// ----------------------------------------------------------------------------
// sha256_pow_verifier_unit_test: self-checking bench for the PoW verifier
// Drives challenge/answer requests into the stream input and programs the
// difficulty threshold over the APB port. Every accepted request is hashed
// by a behavioural SHA-256 model in the bench, and the resulting verdict and
// digest head are checked, in order, against each result transfer.
// ----------------------------------------------------------------------------
module sha256_pow_verifier_unit_test;

  localparam int unsigned IN_W           = spv_pkg::IN_DATA_W;
  localparam int unsigned OUT_W          = spv_pkg::OUT_DATA_W;
  localparam int unsigned ADDR_W         = spv_pkg::CFG_ADDR_W;
  localparam int unsigned STALL_PCT      = 33;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int unsigned PHASES         = 5;
  localparam logic [31:0] THRESHOLD_AT_RESET = 32'h0000_5FFF;

  // Register map: only the difficulty threshold exists, the next slot is empty.
  typedef enum int unsigned {
    REG_DIFFICULTY = 0,
    REG_SPARE      = 1
  } reg_index_t;

  typedef struct {
    logic        accepted;
    logic [31:0] head;
  } verdict_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // Fields from bit 0: challenge_w0[63:0], challenge_w1[127:64],
  // challenge_w2[191:128], challenge_w3[255:192], answer_nonce[287:256].
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // Fields from bit 0: accepted[0], digest_head[32:1], zero fill [39:33].
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // Bench state: threshold as the block should hold it, and verdicts in flight.
  logic [31:0] threshold_shadow = THRESHOLD_AT_RESET;
  verdict_t    pending_verdicts[$];
  bit          quiet = 1'b0;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned accepts_seen = 0;
  int unsigned threshold_writes = 0;
  int unsigned stalled_cycles = 0;

  sha256_pow_verifier_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioural SHA-256 over the single padded block of a 36-byte message.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] digest_head_of(input logic [IN_W-1:0] request);
    logic [7:0]  msg [64];
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, h0;
    // Message bytes sit in the payload lowest byte first; the answer follows
    // the challenge, then the pad byte and the 288-bit length.
    for (int j = 0; j < 64; j++) begin
      if (j < 36) msg[j] = request[8*j +: 8];
      else msg[j] = 8'h00;
    end
    msg[36] = 8'h80;
    msg[62] = 8'h01;
    msg[63] = 8'h20;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg[4*i], msg[4*i+1], msg[4*i+2], msg[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {SHA_IV[0], SHA_IV[1], SHA_IV[2], SHA_IV[3],
                                SHA_IV[4], SHA_IV[5], SHA_IV[6], SHA_IV[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) +
           SHA_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    // Digest bytes 0..3 read little-endian are H0 with its bytes swapped.
    h0 = SHA_IV[0] + a;
    return {h0[7:0], h0[15:8], h0[23:16], h0[31:24]};
  endfunction

  function automatic verdict_t predict_verdict(input logic [IN_W-1:0] request);
    verdict_t v;
    v.head     = digest_head_of(request);
    v.accepted = (v.head <= threshold_shadow);
    return v;
  endfunction

  function automatic logic [IN_W-1:0] pack_request(input logic [63:0] w0, input logic [63:0] w1,
                                                   input logic [63:0] w2, input logic [63:0] w3,
                                                   input logic [31:0] nonce);
    return {nonce, w3, w2, w1, w0};
  endfunction

  function automatic logic [IN_W-1:0] random_request();
    return pack_request({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, $urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, sink back-pressure and the watchdog.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH %s: expected %h, got %h", what, want, got);
    mismatches++;
  endtask

  always @(negedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      verdicts_seen++;
      if (out_tdata[0]) accepts_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result transfer with none outstanding", '0, out_tdata[32:1]);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[0] !== want.accepted)
          report_mismatch("accepted", 32'(want.accepted), 32'(out_tdata[0]));
        if (out_tdata[32:1] !== want.head)
          report_mismatch("digest_head", want.head, out_tdata[32:1]);
        if (out_tdata[OUT_W-1:33] !== '0)
          report_mismatch("zero fill", '0, 32'(out_tdata[OUT_W-1:33]));
      end
    end
  end

  // Counts cycles without any transfer on any port.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending_verdicts.size());
      $display("sha256_pow_verifier_unit_test NOT OK");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side and configuration port.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [IN_W-1:0] request);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < STALL_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = request;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_verdicts.push_back(predict_verdict(request));
    requests_sent++;
  endtask

  // Holds the input off until every verdict is back and the block is idle.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = ADDR_W'(idx * 4);
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    if (idx == REG_DIFFICULTY) begin
      threshold_shadow = value;
      threshold_writes++;
    end
  endtask

  task automatic check_threshold_readback();
    logic [31:0] got;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = ADDR_W'(REG_DIFFICULTY * 4);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (got !== threshold_shadow) report_mismatch("threshold readback", threshold_shadow, got);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset value, and writes to the empty register slot leave the threshold alone.
  task automatic test_register_access();
    check_threshold_readback();
    write_register(REG_SPARE, 32'h0000_0000);
    check_threshold_readback();
    write_register(REG_SPARE, 32'hFFFF_FFFF);
    check_threshold_readback();
  endtask

  // Field extremes and bit patterns at the reset threshold.
  task automatic test_field_extremes();
    send_request(pack_request('0, '0, '0, '0, 32'h0000_0000));
    send_request(pack_request('1, '1, '1, '1, 32'hFFFF_FFFF));
    send_request(pack_request('1, '0, '0, '0, 32'h0000_0000));
    send_request(pack_request('0, '0, '0, '1, 32'h0000_0000));
    send_request(pack_request('0, '0, '0, '0, 32'hFFFF_FFFF));
    send_request(pack_request('0, '0, '0, '0, 32'h0000_0001));
    send_request(pack_request('0, '0, '0, '0, 32'h8000_0000));
    send_request(pack_request({4{16'h5555}}, {4{16'hAAAA}}, {4{16'h5555}}, {4{16'hAAAA}},
                              32'h5555_AAAA));
    send_request(pack_request({4{16'hAAAA}}, {4{16'h5555}}, {4{16'hAAAA}}, {4{16'h5555}},
                              32'hAAAA_5555));
    send_request(pack_request(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
                              64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918,
                              32'h2322_2120));
    wait_drained();
  endtask

  // Threshold exactly at and just below a digest head, then all ones and zero.
  task automatic test_threshold_edges();
    logic [IN_W-1:0] probe;
    logic [31:0]     head;
    probe = random_request();
    head  = digest_head_of(probe);
    write_register(REG_DIFFICULTY, head);
    check_threshold_readback();
    send_request(probe);
    wait_drained();
    write_register(REG_DIFFICULTY, head - 32'd1);
    send_request(probe);
    wait_drained();
    // All ones accepts every answer.
    write_register(REG_DIFFICULTY, 32'hFFFF_FFFF);
    check_threshold_readback();
    send_request(probe);
    send_request(random_request());
    send_request(random_request());
    wait_drained();
    write_register(REG_DIFFICULTY, 32'h0000_0000);
    check_threshold_readback();
    send_request(probe);
    send_request(random_request());
    wait_drained();
  endtask

  // Mostly nonce searches on one challenge, as a solving client would send,
  // with stray unrelated requests mixed in. One phase runs with no idling.
  task automatic test_random_traffic();
    logic [31:0] thresholds [PHASES];
    logic [63:0] cw0, cw1, cw2, cw3;
    logic [31:0] nonce;
    int unsigned run_left;
    int unsigned per_phase;
    thresholds = '{THRESHOLD_AT_RESET, 32'h7FFF_FFFF, $urandom, 32'hFFFF_FFFF,
                   32'h0000_0000};
    per_phase = RANDOM_ITEMS / PHASES;
    run_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_register(REG_DIFFICULTY, thresholds[p]);
      check_threshold_readback();
      quiet = (p == 1);
      for (int n = 0; n < per_phase; n++) begin
        if (run_left == 0) begin
          cw0 = {$urandom, $urandom};
          cw1 = {$urandom, $urandom};
          cw2 = {$urandom, $urandom};
          cw3 = {$urandom, $urandom};
          nonce = ($urandom_range(7) == 0) ? 32'hFFFF_FFF8 : $urandom;
          run_left = $urandom_range(20, 1);
        end
        if ($urandom_range(9) == 0) begin
          send_request(random_request());
        end else begin
          send_request(pack_request(cw0, cw1, cw2, cw3, nonce));
          nonce++;
          run_left--;
        end
        // Once, the sender holds off until the pipeline has fully emptied.
        if (p == 2 && n == per_phase / 2) wait_drained();
      end
      wait_drained();
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_access();
    test_field_extremes();
    test_threshold_edges();
    test_random_traffic();
    wait_drained();

    $display("Checked %0d requests against %0d results, %0d of them accepted,",
             requests_sent, verdicts_seen, accepts_seen);
    $display("over %0d threshold settings including zero and all ones.", threshold_writes);
    if (mismatches == 0) begin
      $display("sha256_pow_verifier_unit_test OK");
    end else begin
      $display("sha256_pow_verifier_unit_test NOT OK");
    end
    $finish;
  end

endmodule
